@@ hdl/dht_pkg.sv @@
// Shared types, codes and constants of the double hashing table.
package dht_pkg;

   localparam int DHT_TABLE_SIZE = 16;
   localparam int KEY_W          = 16;
   localparam int PAYLOAD_W      = 32;
   localparam int SLOT_W         = 4;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_FIND   = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [1:0] RES_INSERTED  = 2'd0;
   localparam logic [1:0] RES_FOUND     = 2'd1;
   localparam logic [1:0] RES_NOT_FOUND = 2'd2;
   localparam logic [1:0] RES_FULL      = 2'd3;

   localparam logic [1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [1:0] SLOT_USED    = 2'd1;
   localparam logic [1:0] SLOT_DELETED = 2'd2;

   typedef struct packed {
      logic [1:0]                  kind;
      logic [KEY_W-1:0]            key;
      logic signed [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  state;
      logic [KEY_W-1:0]            key;
      logic signed [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef enum logic [4:0] {
      FSM_CLEAR = 5'b00001,
      FSM_IDLE  = 5'b00010,
      FSM_QUOT  = 5'b00100,
      FSM_HASH  = 5'b01000,
      FSM_PROBE = 5'b10000
   } fsm_type;

endpackage

@@ hdl/double_hash_table.sv @@
// Open-addressing hash table with double hashing, tombstones and one slot memory.
//
// A transaction is presented on req_data and taken at a rising edge where start
// is high and busy is low. It carries an operation (insert, find or remove), a
// key and a payload that only an insert stores.
// Every transaction yields exactly one result on rsp_data, shown for a single
// cycle with rsp_strobe high. The receiver cannot stall, so no result is held.
// The home slot is the key reduced modulo TABLE_SIZE, and the probe step is one
// plus the key reduced modulo TABLE_SIZE - 2, both by reciprocal multiplication:
// state FSM_QUOT forms both quotients, then state FSM_HASH forms the remainders
// and issues the first slot read. Probing then reads the slot memory once per
// cycle, one to TABLE_SIZE probes. Busy falls with the result, so the next
// transaction can be taken at the edge that ends it: one transaction is in
// flight, and a new one is taken only after the last one has its result. An
// unused operation code skips probing and reports not found from FSM_HASH.
// After reset a clearing pass marks every slot empty, one slot per cycle, and
// busy stays high through the pass, before the first transaction is taken.
// A search that makes TABLE_SIZE probes without success reports a full table on
// insert and not found on find or remove.
module double_hash_table
   import dht_pkg::*;
#(
   parameter int TABLE_SIZE = DHT_TABLE_SIZE
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W      = KEY_W + RECIP_SHIFT + 1;
   localparam logic [IDX_W:0]   DIV_A    = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W:0]   DIV_B    = (IDX_W+1)'(TABLE_SIZE - 2);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
   localparam logic [RECIP_SHIFT:0] RECIP_A =
      (RECIP_SHIFT+1)'((64'd1 << RECIP_SHIFT) / 64'(TABLE_SIZE));
   localparam logic [RECIP_SHIFT:0] RECIP_B =
      (RECIP_SHIFT+1)'((64'd1 << RECIP_SHIFT) / 64'(TABLE_SIZE - 2));

   entry_type slot_mem [TABLE_SIZE];

   fsm_type            state_ff, state_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   req_type            op_ff, op_in;
   logic [KEY_W-1:0]   quot_a_ff, quot_a_in;
   logic [KEY_W-1:0]   quot_b_ff, quot_b_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   stride_ff, stride_in;
   logic [IDX_W-1:0]   probe_cnt_ff, probe_cnt_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   entry_type          rd_data_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic [PROD_W-1:0]  prod_a, prod_b;
   logic [KEY_W-1:0]   rem_a_wide, rem_b_wide;
   logic [IDX_W:0]     rem_a, rem_b, home_wide, step_wide;
   logic [IDX_W:0]     next_pos_wide;
   logic               key_hit;

   always_comb begin
      prod_a     = PROD_W'(op_ff.key) * PROD_W'(RECIP_A);
      prod_b     = PROD_W'(op_ff.key) * PROD_W'(RECIP_B);
      rem_a_wide = op_ff.key - quot_a_ff * KEY_W'(TABLE_SIZE);
      rem_b_wide = op_ff.key - quot_b_ff * KEY_W'(TABLE_SIZE - 2);
      rem_a      = rem_a_wide[IDX_W:0];
      rem_b      = rem_b_wide[IDX_W:0];
      home_wide  = (rem_a >= DIV_A) ? rem_a - DIV_A : rem_a;
      step_wide  = (rem_b >= DIV_B) ? rem_b - DIV_B : rem_b;
      if (pos_ff >= stride_ff) begin
         next_pos_wide = {1'b0, pos_ff} - {1'b0, stride_ff};
      end else begin
         next_pos_wide = {1'b0, pos_ff} + DIV_A - {1'b0, stride_ff};
      end
      key_hit = (rd_data_ff.state == SLOT_USED) && (rd_data_ff.key == op_ff.key);
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      op_in         = op_ff;
      quot_a_in     = quot_a_ff;
      quot_b_in     = quot_b_ff;
      pos_in        = pos_ff;
      stride_in     = stride_ff;
      probe_cnt_in  = probe_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = rd_data_ff;

      case (state_ff)
         FSM_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clr_idx_ff;
            wr_data.state = SLOT_EMPTY;
            clr_idx_in    = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (start) begin
               op_in    = req_data;
               state_in = FSM_QUOT;
            end
         end
         FSM_QUOT: begin
            quot_a_in = prod_a[RECIP_SHIFT +: KEY_W];
            quot_b_in = prod_b[RECIP_SHIFT +: KEY_W];
            state_in  = FSM_HASH;
         end
         FSM_HASH: begin
            pos_in       = home_wide[IDX_W-1:0];
            stride_in    = step_wide[IDX_W-1:0] + 1'b1;
            probe_cnt_in = '0;
            rd_addr      = home_wide[IDX_W-1:0];
            if (op_ff.kind inside {KIND_INSERT, KIND_FIND, KIND_REMOVE}) begin
               state_in = FSM_PROBE;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{status: RES_NOT_FOUND, slot: '0};
               state_in      = FSM_IDLE;
            end
         end
         FSM_PROBE: begin
            if (op_ff.kind == KIND_INSERT &&
                (rd_data_ff.state inside {SLOT_EMPTY, SLOT_DELETED})) begin
               wr_en         = 1'b1;
               wr_data       = '{state: SLOT_USED, key: op_ff.key, payload: op_ff.payload};
               rsp_strobe_in = 1'b1;
               rsp_in        = '{status: RES_INSERTED, slot: SLOT_W'(pos_ff)};
               state_in      = FSM_IDLE;
            end else if (op_ff.kind != KIND_INSERT && rd_data_ff.state == SLOT_EMPTY) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{status: RES_NOT_FOUND, slot: '0};
               state_in      = FSM_IDLE;
            end else if (op_ff.kind != KIND_INSERT && key_hit) begin
               wr_en         = (op_ff.kind == KIND_REMOVE);
               wr_data.state = SLOT_DELETED;
               rsp_strobe_in = 1'b1;
               rsp_in        = '{status: RES_FOUND, slot: SLOT_W'(pos_ff)};
               state_in      = FSM_IDLE;
            end else if (probe_cnt_ff == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_in.slot   = '0;
               rsp_in.status = (op_ff.kind == KIND_INSERT) ? RES_FULL : RES_NOT_FOUND;
               state_in      = FSM_IDLE;
            end else begin
               pos_in       = next_pos_wide[IDX_W-1:0];
               rd_addr      = next_pos_wide[IDX_W-1:0];
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_CLEAR;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      quot_a_ff    <= quot_a_in;
      quot_b_ff    <= quot_b_in;
      pos_ff       <= pos_in;
      stride_ff    <= stride_in;
      probe_cnt_ff <= probe_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != FSM_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ tb/double_hash_table_tb.sv @@
// Self-checking testbench of double_hash_table: a directed table, then random transactions.
`timescale 1ns / 100ps

module double_hash_table_tb;
   import dht_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 20;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 2 * (18 + DHT_TABLE_SIZE);

   typedef struct packed {
      logic [1:0]                  kind;
      logic [KEY_W-1:0]            key;
      logic signed [PAYLOAD_W-1:0] payload;
      int                          reps;
      bit                          fixed;
      logic [1:0]                  fixed_status;
      logic [SLOT_W-1:0]           fixed_slot;
   } script_row;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   bit      req_fixed;
   rsp_type req_fixed_rsp;

   logic [1:0]                  shadow_state   [DHT_TABLE_SIZE];
   logic [KEY_W-1:0]            shadow_key     [DHT_TABLE_SIZE];
   logic signed [PAYLOAD_W-1:0] shadow_payload [DHT_TABLE_SIZE];

   rsp_type pending_results[$];
   int      error_count;
   int      accepted_count;
   int      status_seen [4];

   double_hash_table u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL double_hash_table");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   function automatic int used_slots();
      int n;
      n = 0;
      for (int i = 0; i < DHT_TABLE_SIZE; i++) begin
         if (shadow_state[i] == SLOT_USED) begin
            n++;
         end
      end
      return n;
   endfunction

   // Walks the probe path of one transaction and updates the shadow table.
   function automatic rsp_type probe_table(input req_type r);
      rsp_type     res;
      int unsigned pos;
      int unsigned stride;
      bit          done;
      res.status = (r.kind == KIND_INSERT) ? RES_FULL : RES_NOT_FOUND;
      res.slot   = '0;
      pos        = r.key % DHT_TABLE_SIZE;
      stride     = 1 + r.key % (DHT_TABLE_SIZE - 2);
      done       = (r.kind == KIND_UNUSED);
      for (int n = 0; n < DHT_TABLE_SIZE && !done; n++) begin
         if (r.kind == KIND_INSERT) begin
            if (shadow_state[pos] == SLOT_EMPTY || shadow_state[pos] == SLOT_DELETED) begin
               shadow_state[pos]   = SLOT_USED;
               shadow_key[pos]     = r.key;
               shadow_payload[pos] = r.payload;
               res.status          = RES_INSERTED;
               res.slot            = pos[SLOT_W-1:0];
               done                = 1'b1;
            end
         end else if (shadow_state[pos] == SLOT_EMPTY) begin
            done = 1'b1;
         end else if (shadow_state[pos] == SLOT_USED && shadow_key[pos] == r.key) begin
            if (r.kind == KIND_REMOVE) begin
               shadow_state[pos] = SLOT_DELETED;
            end
            res.status = RES_FOUND;
            res.slot   = pos[SLOT_W-1:0];
            done       = 1'b1;
         end
         if (!done) begin
            pos = (pos >= stride) ? pos - stride : pos + DHT_TABLE_SIZE - stride;
         end
      end
      return res;
   endfunction

   // Results are checked before the expectation of a transaction taken at the same edge is queued.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                         rsp_data.status, rsp_data.slot));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               end
               if (rsp_data.slot !== want.slot) begin
                  report_mismatch($sformatf("slot %0d, expected %0d",
                                            rsp_data.slot, want.slot));
               end
               status_seen[want.status]++;
            end
         end
         if (start && !busy) begin
            want = probe_table(req_data);
            if (req_fixed) begin
               want = req_fixed_rsp;
            end
            pending_results.push_back(want);
            accepted_count++;
         end
      end
   end

   task automatic issue(input req_type item, input bit fixed, input rsp_type fixed_rsp);
      start         <= 1'b1;
      req_data      <= item;
      req_fixed     <= fixed;
      req_fixed_rsp <= fixed_rsp;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
   endtask

   initial begin : stimulus
      script_row             directed_script [DIRECTED_ROWS];
      req_type               item;
      rsp_type               fixed_rsp;
      logic [KEY_W-1:0]      key_pool[$];
      int                    burst_left;
      int                    gap;
      int                    pick;
      int                    directed_items;

      for (int i = 0; i < DHT_TABLE_SIZE; i++) begin
         shadow_state[i]   = SLOT_EMPTY;
         shadow_key[i]     = '0;
         shadow_payload[i] = '0;
      end
      error_count    = 0;
      accepted_count = 0;
      directed_items = 0;
      status_seen    = '{default: 0};
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      req_fixed      = 1'b0;
      req_fixed_rsp  = '0;

      directed_script[0]  = '{KIND_FIND,   16'h0000, 32'sd0,          1,  1'b1, RES_NOT_FOUND, 4'd0};
      directed_script[1]  = '{KIND_REMOVE, 16'hFFFF, 32'sd0,          1,  1'b1, RES_NOT_FOUND, 4'd0};
      directed_script[2]  = '{KIND_UNUSED, 16'h1234, -32'sd1,         1,  1'b1, RES_NOT_FOUND, 4'd0};
      directed_script[3]  = '{KIND_INSERT, 16'h0000, 32'sh8000_0000,  1,  1'b1, RES_INSERTED,  4'd0};
      directed_script[4]  = '{KIND_INSERT, 16'hFFFF, 32'sh7FFF_FFFF,  1,  1'b1, RES_INSERTED,  4'd15};
      directed_script[5]  = '{KIND_FIND,   16'h0000, 32'sd0,          1,  1'b1, RES_FOUND,     4'd0};
      directed_script[6]  = '{KIND_FIND,   16'hFFFF, 32'sd0,          1,  1'b1, RES_FOUND,     4'd15};
      directed_script[7]  = '{KIND_FIND,   16'h0010, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[8]  = '{KIND_INSERT, 16'h0010, 32'sd5,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[9]  = '{KIND_FIND,   16'h0010, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[10] = '{KIND_REMOVE, 16'h0010, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[11] = '{KIND_FIND,   16'h0010, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[12] = '{KIND_INSERT, 16'h0000, 32'shAAAA_5555,  14, 1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[13] = '{KIND_INSERT, 16'h0005, 32'sd0,          1,  1'b1, RES_FULL,      4'd0};
      directed_script[14] = '{KIND_FIND,   16'h0007, 32'sd0,          1,  1'b1, RES_NOT_FOUND, 4'd0};
      directed_script[15] = '{KIND_REMOVE, 16'h0000, 32'sd0,          1,  1'b1, RES_FOUND,     4'd0};
      directed_script[16] = '{KIND_FIND,   16'h0000, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[17] = '{KIND_INSERT, 16'h0010, -32'sd2,         1,  1'b1, RES_INSERTED,  4'd0};
      directed_script[18] = '{KIND_REMOVE, 16'h0009, 32'sd0,          1,  1'b0, RES_NOT_FOUND, 4'd0};
      directed_script[19] = '{KIND_REMOVE, 16'hFFFF, 32'sd0,          1,  1'b1, RES_FOUND,     4'd15};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_script[r]) begin
         for (int n = 0; n < directed_script[r].reps; n++) begin
            item.kind        = directed_script[r].kind;
            item.key         = directed_script[r].key;
            item.payload     = directed_script[r].payload;
            fixed_rsp.status = directed_script[r].fixed_status;
            fixed_rsp.slot   = directed_script[r].fixed_slot;
            issue(item, directed_script[r].fixed, fixed_rsp);
            directed_items++;
         end
      end
      hold_until_drained();

      fixed_rsp  = '0;
      burst_left = $urandom_range(1, 40);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            item.kind = KIND_UNUSED;
         end else if (used_slots() >= 12) begin
            item.kind = (pick < 25) ? KIND_INSERT : (pick < 50) ? KIND_FIND : KIND_REMOVE;
         end else begin
            item.kind = (pick < 50) ? KIND_INSERT : (pick < 75) ? KIND_FIND : KIND_REMOVE;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60 && key_pool.size() != 0) begin
            item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else if (pick < 80) begin
            item.key = KEY_W'($urandom_range(0, 63));
         end else begin
            item.key = KEY_W'($urandom_range(0, 65535));
         end
         item.payload = $urandom;
         if (item.kind == KIND_INSERT) begin
            key_pool.push_back(item.key);
            if (key_pool.size() > 24) begin
               void'(key_pool.pop_front());
            end
         end
         issue(item, 1'b0, fixed_rsp);

         if (i == RANDOM_ITEMS / 2) begin
            hold_until_drained();
         end
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 40);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      while (pending_results.size() != 0) begin
         void'(pending_results.pop_front());
         report_mismatch("expected result never arrived");
      end

      $display("Sent %0d transactions, %0d of them from the directed table of %0d rows.",
               accepted_count, directed_items, DIRECTED_ROWS);
      $display("Results seen: %0d inserted, %0d found or removed, %0d not found, %0d table full.",
               status_seen[RES_INSERTED], status_seen[RES_FOUND],
               status_seen[RES_NOT_FOUND], status_seen[RES_FULL]);
      if (error_count == 0) begin
         $display("PASS double_hash_table");
      end else begin
         $display("FAIL double_hash_table");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/dht_pkg.sv
hdl/double_hash_table.sv
tb/double_hash_table_tb.sv
